### design/mrsp_pkg.sv
// ----------------------------------------------------------------------------
// mrsp_pkg: shared types and constants of the Modbus RTU sensor poller
// Sensor count, request/reply codes, queue item layout and the CRC-16 step.
// ----------------------------------------------------------------------------
package mrsp_pkg;

  // Number of polled sensors and the width of a sensor index
  localparam int SENSORS = 6;
  localparam int SENS_W  = (SENSORS > 1) ? $clog2(SENSORS) : 1;

  // Stream payload widths
  localparam int IN_W  = 56;
  localparam int OUT_W = 32;

  // Configuration port
  localparam int REG_IDX_W = 1;
  localparam int REG_W     = 16;
  localparam logic [REG_IDX_W-1:0] REG_TARGET = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_BASE   = 1'd1;

  // Modbus codes
  localparam logic [7:0]  FUNC_READ      = 8'h03;
  localparam logic [7:0]  REPLY_COUNT    = 8'h02;
  localparam logic [7:0]  REG_COUNT_HI   = 8'h00;
  localparam logic [7:0]  REG_COUNT_LO   = 8'h01;
  localparam logic [15:0] RESET_DISTANCE = 16'd6666;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  // Reply status codes
  localparam logic [2:0] ST_NONE = 3'd0;
  localparam logic [2:0] ST_OK   = 3'd1;
  localparam logic [2:0] ST_CRC  = 3'd2;
  localparam logic [2:0] ST_HDR  = 3'd3;
  localparam logic [2:0] ST_ADDR = 3'd4;

  // Byte positions inside the request frame
  localparam logic [2:0] BYTE_ADDR   = 3'd0;
  localparam logic [2:0] BYTE_FUNC   = 3'd1;
  localparam logic [2:0] BYTE_REG_HI = 3'd2;
  localparam logic [2:0] BYTE_REG_LO = 3'd3;
  localparam logic [2:0] BYTE_CNT_HI = 3'd4;
  localparam logic [2:0] BYTE_CNT_LO = 3'd5;
  localparam logic [2:0] BYTE_CRC_LO = 3'd6;
  localparam logic [2:0] BYTE_CRC_HI = 3'd7;

  // Reply bytes covered by the CRC
  localparam logic [2:0] REPLY_CRC_LAST = 3'd4;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  // Classified poll tick
  typedef enum logic [2:0] {
    K_FIRST,
    K_NOREPLY,
    K_HDR,
    K_ADDR,
    K_REPLY
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [SENS_W-1:0] idx;
    logic [7:0]        addr;
    logic [7:0]        data_hi;
    logic [7:0]        data_lo;
    logic [7:0]        crc_lo;
    logic [7:0]        crc_hi;
  } item_t;

  // One byte through the reflected CRC-16/Modbus
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Byte k of the read request frame
  function automatic logic [7:0] req_byte(input logic [2:0]  k,
                                          input logic [7:0]  addr,
                                          input logic [15:0] tgt,
                                          input logic [15:0] crc);
    logic [7:0] b;
    unique case (k)
      BYTE_ADDR:   b = addr;
      BYTE_FUNC:   b = FUNC_READ;
      BYTE_REG_HI: b = tgt[15:8];
      BYTE_REG_LO: b = tgt[7:0];
      BYTE_CNT_HI: b = REG_COUNT_HI;
      BYTE_CNT_LO: b = REG_COUNT_LO;
      BYTE_CRC_LO: b = crc[7:0];
      BYTE_CRC_HI: b = crc[15:8];
      default:     b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### design/mrsp_front.sv
// ----------------------------------------------------------------------------
// mrsp_front: poll tick intake
// Accepts poll ticks, checks the reply header and address and tags each tick.
// ----------------------------------------------------------------------------
module mrsp_front import mrsp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // addr, func, count, data_hi, data_lo, crc_lo, crc_hi
  input  logic             s_tuser,   // command
  input  logic [7:0]       base_address,
  input  logic             q_full,
  output logic             q_push,
  output item_t            q_item
);

  logic       started;
  logic [7:0] r_addr, r_func, r_count;
  logic [7:0] addr_off;
  logic       hdr_ok, addr_ok;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;

  // Unpack the reply bytes
  assign r_addr  = s_tdata[7:0];
  assign r_func  = s_tdata[15:8];
  assign r_count = s_tdata[23:16];

  assign addr_off = r_addr - base_address;
  assign hdr_ok   = (r_func == FUNC_READ) && (r_count == REPLY_COUNT);
  assign addr_ok  = addr_off < 8'(SENSORS);

  // Classify the tick
  always_comb begin
    q_item.idx     = addr_off[SENS_W-1:0];
    q_item.addr    = r_addr;
    q_item.data_hi = s_tdata[31:24];
    q_item.data_lo = s_tdata[39:32];
    q_item.crc_lo  = s_tdata[47:40];
    q_item.crc_hi  = s_tdata[55:48];
    if (!started) begin
      q_item.kind = K_FIRST;
    end else if (!s_tuser) begin
      q_item.kind = K_NOREPLY;
    end else if (!hdr_ok) begin
      q_item.kind = K_HDR;
    end else if (!addr_ok) begin
      q_item.kind = K_ADDR;
    end else begin
      q_item.kind = K_REPLY;
    end
  end

  // Mark the first tick as seen
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
    end else if (q_push) begin
      started <= 1'b1;
    end
  end

endmodule

### design/mrsp_queue.sv
// ----------------------------------------------------------------------------
// mrsp_queue: short queue of classified poll ticks
// Decouples the intake from the request sequencer.
// ----------------------------------------------------------------------------
module mrsp_queue import mrsp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t pop_item,
  output logic  not_empty
);

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = entries[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

### design/mrsp_back.sv
// ----------------------------------------------------------------------------
// mrsp_back: reply evaluation and request sequencer
// Checks reply CRC, updates the sensor table, scans for the minimum and
// streams the 8-byte read request.
// ----------------------------------------------------------------------------
module mrsp_back import mrsp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [15:0]      target_register,
  input  logic [7:0]       base_address,
  input  logic             q_valid,
  input  item_t            q_item,
  output logic             q_pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // tx_byte, reply_status, min_distance, min_sensor
  output logic             m_tlast    // tx_last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CRC,
    S_UPDATE,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t            state;
  item_t             item;
  logic [2:0]        cnt;
  logic [15:0]       rcrc, tcrc;
  logic [2:0]        status;
  logic [SENS_W-1:0] poll_index, next_poll, best, scan_i;
  logic [15:0]       best_dist, scan_dist;
  logic [15:0]       dist_table [SENSORS];
  logic [SENSORS-1:0] valid_flags;
  logic [7:0]        rbyte, tbyte, obyte;
  logic              emit_go;

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign next_poll = (poll_index == SENS_W'(SENSORS - 1)) ? '0 : poll_index + SENS_W'(1);
  assign scan_i    = cnt[SENS_W-1:0];
  assign scan_dist = dist_table[scan_i];
  assign emit_go   = (state == S_EMIT) && (!m_tvalid || m_tready);

  // Reply byte covered by the CRC at this step
  always_comb begin
    case (cnt)
      3'd0:    rbyte = item.addr;
      3'd1:    rbyte = FUNC_READ;
      3'd2:    rbyte = REPLY_COUNT;
      3'd3:    rbyte = item.data_hi;
      3'd4:    rbyte = item.data_lo;
      default: rbyte = 8'h00;
    endcase
  end

  assign tbyte = req_byte(cnt, base_address + 8'(next_poll), target_register, tcrc);
  assign obyte = req_byte(cnt, base_address + 8'(poll_index), target_register, tcrc);

  // Sequencer, sensor table and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      poll_index  <= SENS_W'(SENSORS - 1);
      valid_flags <= '0;
      m_tvalid    <= 1'b0;
      for (int i = 0; i < SENSORS; i++) begin
        dist_table[i] <= RESET_DISTANCE;
      end
    end else begin
      if (emit_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            item  <= q_item;
            cnt   <= '0;
            rcrc  <= CRC_INIT;
            tcrc  <= CRC_INIT;
            state <= S_CRC;
          end
        end
        // Run reply and request CRCs side by side, one byte a cycle
        S_CRC: begin
          if (cnt <= REPLY_CRC_LAST) begin
            rcrc <= crc16_byte(rcrc, rbyte);
          end
          tcrc <= crc16_byte(tcrc, tbyte);
          if (cnt == BYTE_CNT_LO) begin
            state <= S_UPDATE;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        // Apply the reply and advance round-robin
        S_UPDATE: begin
          unique case (item.kind)
            K_FIRST: status <= ST_NONE;
            K_NOREPLY: begin
              status <= ST_NONE;
              valid_flags[poll_index] <= 1'b0;
            end
            K_HDR:  status <= ST_HDR;
            K_ADDR: status <= ST_ADDR;
            K_REPLY: begin
              if (rcrc == {item.crc_hi, item.crc_lo}) begin
                dist_table[item.idx]  <= {item.data_hi, item.data_lo};
                valid_flags[item.idx] <= 1'b1;
                status                <= ST_OK;
              end else begin
                valid_flags[item.idx] <= 1'b0;
                status                <= ST_CRC;
              end
            end
            default: status <= ST_NONE;
          endcase
          poll_index <= next_poll;
          cnt        <= '0;
          state      <= S_SCAN;
        end
        // Walk the table; sensor 0 is the default pick
        S_SCAN: begin
          if (cnt == '0) begin
            best      <= '0;
            best_dist <= scan_dist;
          end else if (valid_flags[scan_i] && (scan_dist < best_dist)) begin
            best      <= scan_i;
            best_dist <= scan_dist;
          end
          if (scan_i == SENS_W'(SENSORS - 1)) begin
            cnt   <= '0;
            state <= S_EMIT;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        // Stream the request bytes
        S_EMIT: begin
          if (emit_go) begin
            m_tdata  <= {2'b00, 3'(best), best_dist, status, obyte};
            m_tlast  <= (cnt == BYTE_CRC_HI);
            cnt      <= cnt + 3'd1;
            if (cnt == BYTE_CRC_HI) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Round-robin pointer stays inside the sensor range
  a_poll_range: assert property (@(posedge clk) disable iff (rst)
    poll_index <= SENS_W'(SENSORS - 1))
    else $error("poll index out of sensor range");

  // Accepted status comes only from a well-formed in-range reply
  a_ok_kind: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && status == ST_OK) |-> (item.kind == K_REPLY))
    else $error("accepted status without a reply");

  // Minimum pick is sensor 0 or a valid sensor
  a_best_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (best == '0 || valid_flags[best]))
    else $error("minimum pick is an invalid sensor");

  // A queued tick is taken only when the sequencer is free
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == S_CRC && cnt == '0))
    else $error("tick popped without starting CRC");

endmodule

### design/modbus_rtu_sensor_poller.sv
// Path: a tick passes through the queue, 6 CRC byte steps, the update and the
//   table scan before its first request byte reaches the output.
// Order: the sequencer takes the next tick only once all 8 request bytes of
//   the last are sent; CRC, min scan and output bytes run one after another.
// Reset: synchronous; distances return to 6666, flags clear, registers
//   return to target 0 and base address 1. No clearing pass.
// ----------------------------------------------------------------------------
// modbus_rtu_sensor_poller: Modbus RTU round-robin distance poller
// Evaluates each reply, keeps the sensor table and emits read requests.
// ----------------------------------------------------------------------------
module modbus_rtu_sensor_poller import mrsp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_W-1:0]      s_tdata,   // reply_addr, reply_func, reply_count,
                                          // reply_data_hi, reply_data_lo,
                                          // reply_crc_lo, reply_crc_hi
  input  logic                 s_tuser,   // command
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,   // tx_byte, reply_status, min_distance,
                                          // min_sensor, zero pad
  output logic                 m_tlast,   // tx_last
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_addr,
  input  logic [REG_W-1:0]     cfg_wdata
);

  logic [15:0] target_register;
  logic [7:0]  base_address;
  logic        q_full, q_push, q_pop, q_valid;
  item_t       push_item, pop_item;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_register <= 16'd0;
      base_address    <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TARGET: target_register <= cfg_wdata;
        REG_BASE:   base_address    <= cfg_wdata[7:0];
        default:    ;
      endcase
    end
  end

  mrsp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .base_address (base_address),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  mrsp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .not_empty (q_valid)
  );

  mrsp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .target_register (target_register),
    .base_address    (base_address),
    .q_valid         (q_valid),
    .q_item          (pop_item),
    .q_pop           (q_pop),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tlast         (m_tlast)
  );

endmodule

### sim/tb_modbus_rtu_sensor_poller.sv
// ----------------------------------------------------------------------------
// tb_modbus_rtu_sensor_poller: testbench of the Modbus RTU sensor poller
// Sends poll ticks with good, corrupt, missing and misaddressed replies
// under several register settings and random stalls on both streams.
// A predictor works out each 8-byte read request together with the reply
// status and the minimum pick. Every output byte is checked in order.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_sensor_poller;
  import mrsp_pkg::*;

  // One poll tick as the sender sees it
  typedef struct packed {
    logic       cmd;
    logic [7:0] chi;
    logic [7:0] clo;
    logic [7:0] dlo;
    logic [7:0] dhi;
    logic [7:0] cnt;
    logic [7:0] func;
    logic [7:0] addr;
  } tick_t;

  // One request byte with its side fields
  typedef struct packed {
    logic [7:0]  tx;
    logic        last;
    logic [2:0]  status;
    logic [15:0] min_dist;
    logic [2:0]  sensor;
  } req_byte_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata;
  logic                 s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [OUT_W-1:0]     m_tdata;
  logic                 m_tlast;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_addr;
  logic [REG_W-1:0]     cfg_wdata;

  // Predictor state and register copies
  logic [15:0] dist_tab [SENSORS];
  bit          valid_tab [SENSORS];
  int          poll_idx;
  bit          started;
  logic [15:0] tgt_reg;
  logic [7:0]  base_addr;

  req_byte_t   pending_bytes [$];
  int          err_count;
  bit          idle_on;
  int          sink_hold;
  int          sink_stall;

  modbus_rtu_sensor_poller u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // CRC-16/Modbus over the first n bytes of msg, byte 0 in the low bits
  function automatic logic [15:0] modbus_crc(input logic [63:0] msg, input int n);
    logic [15:0] c;
    c = CRC_INIT;
    for (int i = 0; i < n; i++) begin
      c = c ^ {8'h00, msg[8*i +: 8]};
      for (int b = 0; b < 8; b++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
    end
    return c;
  endfunction

  // Well-formed reply from sensor idx with a correct CRC
  function automatic tick_t make_reply(input int idx, input logic [15:0] d);
    tick_t       t;
    logic [15:0] c;
    t.cmd  = 1'b1;
    t.addr = base_addr + 8'(idx);
    t.func = FUNC_READ;
    t.cnt  = REPLY_COUNT;
    t.dhi  = d[15:8];
    t.dlo  = d[7:0];
    c = modbus_crc({24'h0, t.dlo, t.dhi, t.cnt, t.func, t.addr}, 5);
    t.clo  = c[7:0];
    t.chi  = c[15:8];
    return t;
  endfunction

  // Evaluate one accepted tick and queue the 8 request bytes it yields
  function automatic void predict_tick(input tick_t t);
    logic [2:0]  st;
    logic [7:0]  off;
    logic [7:0]  dest;
    logic [15:0] c;
    logic [63:0] frame;
    int          best;
    req_byte_t   rb;
    st = ST_NONE;
    if (!started) begin
      started = 1'b1;
    end else if (t.cmd) begin
      off = t.addr - base_addr;
      if (t.func != FUNC_READ || t.cnt != REPLY_COUNT) begin
        st = ST_HDR;
      end else if (off >= SENSORS) begin
        st = ST_ADDR;
      end else if (modbus_crc({24'h0, t.dlo, t.dhi, t.cnt, t.func, t.addr}, 5)
                   == {t.chi, t.clo}) begin
        dist_tab[off]  = {t.dhi, t.dlo};
        valid_tab[off] = 1'b1;
        st = ST_OK;
      end else begin
        valid_tab[off] = 1'b0;
        st = ST_CRC;
      end
    end else begin
      valid_tab[poll_idx] = 1'b0;
    end
    poll_idx = (poll_idx == SENSORS - 1) ? 0 : poll_idx + 1;
    dest  = base_addr + 8'(poll_idx);
    frame = {16'h0, REG_COUNT_LO, REG_COUNT_HI, tgt_reg[7:0], tgt_reg[15:8],
             FUNC_READ, dest};
    c = modbus_crc(frame, 6);
    frame[63:48] = {c[15:8], c[7:0]};
    // Sensor 0 is the default pick; others win only when valid and smaller
    best = 0;
    for (int i = 1; i < SENSORS; i++) begin
      if (valid_tab[i] && dist_tab[i] < dist_tab[best]) best = i;
    end
    for (int k = 0; k < 8; k++) begin
      rb.tx       = frame[8*k +: 8];
      rb.last     = (k == 7);
      rb.status   = st;
      rb.min_dist = dist_tab[best];
      rb.sensor   = 3'(best);
      pending_bytes.push_back(rb);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
    err_count++;
  endtask

  // Offer one tick, optionally after an idle burst, and wait for acceptance
  task automatic send_tick(input tick_t t);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 15);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= t.cmd;
    s_tdata  <= {t.chi, t.clo, t.dlo, t.dhi, t.cnt, t.func, t.addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_tick(t);
  endtask

  // Drop valid and let every pending request byte drain
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_TARGET) tgt_reg = val;
    else base_addr = val[7:0];
  endtask

  // Random tick: mostly good replies, plus corrupt, missing, bad and noise
  function automatic tick_t random_tick();
    tick_t       t;
    logic [63:0] raw;
    int          r;
    int          idx;
    logic [15:0] d;
    r   = $urandom_range(0, 99);
    idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SENSORS - 1) : poll_idx;
    d   = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 400));
    raw = {$urandom, $urandom};
    t   = make_reply(idx, d);
    if (r < 55) begin
      // keep the good reply
    end else if (r < 67) begin
      t.chi = t.chi ^ raw[7:0];
      t.clo = t.clo ^ raw[15:8];
      if (raw[15:0] == 16'h0) t.clo = ~t.clo;
    end else if (r < 77) begin
      t     = raw[$bits(tick_t)-1:0];
      t.cmd = 1'b0;
    end else if (r < 85) begin
      if (raw[16]) begin
        t.func = raw[7:0];
        if (t.func == FUNC_READ) t.func = ~t.func;
      end else begin
        t.cnt = raw[7:0];
        if (t.cnt == REPLY_COUNT) t.cnt = ~t.cnt;
      end
    end else if (r < 93) begin
      t.addr = base_addr + 8'($urandom_range(SENSORS, 255));
    end else begin
      t = raw[$bits(tick_t)-1:0];
    end
    return t;
  endfunction

  // Compare each accepted request byte with the oldest expectation
  always @(posedge clk) begin : check_out
    req_byte_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected byte", m_tdata, 32'h0);
      end else begin
        want = pending_bytes.pop_front();
        if (m_tdata[7:0] !== want.tx)
          report_mismatch("tx_byte", 32'(m_tdata[7:0]), 32'(want.tx));
        if (m_tlast !== want.last)
          report_mismatch("tx_last", 32'(m_tlast), 32'(want.last));
        if (m_tdata[10:8] !== want.status)
          report_mismatch("reply_status", 32'(m_tdata[10:8]), 32'(want.status));
        if (m_tdata[26:11] !== want.min_dist)
          report_mismatch("min_distance", 32'(m_tdata[26:11]), 32'(want.min_dist));
        if (m_tdata[29:27] !== want.sensor)
          report_mismatch("min_sensor", 32'(m_tdata[29:27]), 32'(want.sensor));
      end
    end
  end

  // Sink ready: long hold when asked, random stall bursts otherwise
  initial begin
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        m_tready <= 1'b0;
        sink_hold--;
      end else if (sink_stall > 0) begin
        m_tready <= 1'b0;
        sink_stall--;
      end else begin
        m_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 9) == 0) sink_stall = $urandom_range(1, 15);
      end
    end
  end

  task automatic test_directed();
    tick_t t;
    send_tick(make_reply(0, 16'd5));              // first tick ignores the reply
    send_tick(make_reply(0, 16'h0000));
    send_tick(make_reply(1, 16'hFFFF));
    send_tick(make_reply(2, 16'd100));
    send_tick(make_reply(3, 16'd100));            // tie does not replace the pick
    send_tick(make_reply(4, 16'd50));
    t = make_reply(5, 16'd7);
    t.cmd = 1'b0;
    send_tick(t);                                 // no reply clears last polled
    t = make_reply(4, 16'd3);
    t.clo = ~t.clo;
    send_tick(t);                                 // CRC error keeps the distance
    t = make_reply(1, 16'd9);
    t.func = 8'h04;
    send_tick(t);
    t = make_reply(1, 16'd9);
    t.cnt = 8'h03;
    send_tick(t);
    t = make_reply(0, 16'd9);
    t.addr = base_addr - 8'd1;
    send_tick(t);                                 // address just below range
    t = make_reply(0, 16'd9);
    t.addr = base_addr + 8'(SENSORS);
    send_tick(t);                                 // address just above range
    t = make_reply(0, 16'd9);
    t.addr = 8'hFF;
    send_tick(t);
    send_tick(make_reply(5, 16'd1));              // reply from a sensor not polled
    send_tick(make_reply(0, 16'hFFFF));
    t = '1;
    send_tick(t);
    t = '0;
    t.cmd = 1'b1;
    send_tick(t);
    t = '1;
    t.cmd = 1'b0;
    send_tick(t);
    send_tick(make_reply(2, 16'h0000));
    t = make_reply(3, 16'd20);
    t.clo = 8'hFF;
    t.chi = 8'hFF;
    if ({t.chi, t.clo} == modbus_crc({24'h0, t.dlo, t.dhi, t.cnt, t.func, t.addr}, 5))
      t.clo = 8'h00;
    send_tick(t);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    write_reg(REG_TARGET, 16'hFFFF);
    write_reg(REG_BASE, 16'd247);
    repeat (30) send_tick(random_tick());
    wait_idle();
    write_reg(REG_TARGET, 16'h0000);
    write_reg(REG_BASE, 16'd254);                 // sensor addresses wrap past 255
    repeat (30) send_tick(random_tick());
    wait_idle();
    write_reg(REG_BASE, 16'd1);
  endtask

  task automatic test_backpressure();
    sink_hold = 300;
    repeat (12) send_tick(random_tick());
    wait_idle();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_TARGET, 16'($urandom));
      write_reg(REG_BASE, 16'($urandom_range(1, 247)));
      if (p == 3) idle_on = 1'b0;
      repeat (100) send_tick(random_tick());
      wait_idle();
    end
  endtask

  initial begin
    clk        = 1'b0;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = 1'b0;
    m_tready   = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = REG_TARGET;
    cfg_wdata  = '0;
    err_count  = 0;
    idle_on    = 1'b1;
    sink_hold  = 0;
    sink_stall = 0;
    for (int i = 0; i < SENSORS; i++) begin
      dist_tab[i]  = RESET_DISTANCE;
      valid_tab[i] = 1'b0;
    end
    poll_idx  = SENSORS - 1;
    started   = 1'b0;
    tgt_reg   = 16'h0000;
    base_addr = 8'd1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random_phases();

    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### modbus_rtu_sensor_poller.f
design/mrsp_pkg.sv
design/mrsp_front.sv
design/mrsp_queue.sv
design/mrsp_back.sv
design/modbus_rtu_sensor_poller.sv
sim/tb_modbus_rtu_sensor_poller.sv
